### rtl/khbd_pkg.sv
// Shared constants, opcodes and controller/datapath interface types for the keyed draw block.
package khbd_pkg;

    // Input opcodes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_DELTA = 2'd1;
    localparam logic [1:0] OP_UNIT  = 2'd2;

    // Hash and mixer constants
    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;   // prime is 2^40 + this
    localparam int          FNV_PRIME_SH = 40;
    localparam logic [63:0] MIX_GAMMA    = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2     = 64'h94D049BB133111EB;

    // Datapath operation codes
    typedef logic [3:0] dp_op_t;
    localparam dp_op_t DP_NOP  = 4'd0;
    localparam dp_op_t DP_HASH = 4'd1;
    localparam dp_op_t DP_LOAD = 4'd2;
    localparam dp_op_t DP_XS30 = 4'd3;
    localparam dp_op_t DP_MUL  = 4'd4;
    localparam dp_op_t DP_XS27 = 4'd5;
    localparam dp_op_t DP_XS31 = 4'd6;
    localparam dp_op_t DP_KEY  = 4'd7;
    localparam dp_op_t DP_DIV  = 4'd8;
    localparam dp_op_t DP_OUT  = 4'd9;

    // Multiply partial-product phases
    typedef logic [1:0] mul_phase_t;
    localparam mul_phase_t MPH_LL = 2'd0;
    localparam mul_phase_t MPH_LH = 2'd1;
    localparam mul_phase_t MPH_HL = 2'd2;

    typedef struct packed {
        dp_op_t     op;
        logic       mul_sel;     // 0: first mixer constant, 1: second
        mul_phase_t mul_phase;
    } dp_cmd_t;

    typedef struct packed {
        logic is_unit;
        logic bound_zero;
        logic out_busy;
    } dp_stat_t;

endpackage

### rtl/keyed_hash_bounded_draw.sv
// Keyed hash draw block: FNV-1a domain hash, two-round mixer, bounded delta or unit fraction.
// Domain byte: bytes accepted back to back; no result beat.
// Unit draw or zero-bound delta: result beat follows two mixer rounds (each two multiplies
//   on one shared 32x32 multiplier plus xor-shift steps).
// Nonzero-bound delta: a serial remainder over the 64 mixer bits, one bit per cycle, follows.
// Next item is accepted the cycle after a result enters the output register, later while a
//   stalled beat holds the output. Synchronous active-low reset clears control, the seed (to 0)
//   and the hash (to offset basis).
module keyed_hash_bounded_draw (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [63:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [7:0]         s_domain_byte,
    input  logic               s_domain_first,
    input  logic [63:0]        s_draw_index,
    input  logic signed [31:0] s_delta_bound,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_unit,
    output logic signed [31:0] m_delta,
    output logic [52:0]        m_unit_fraction
);
    import khbd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    khbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .stat    (stat),
        .cmd     (cmd)
    );

    khbd_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_op            (s_op),
        .s_domain_byte   (s_domain_byte),
        .s_domain_first  (s_domain_first),
        .s_draw_index    (s_draw_index),
        .s_delta_bound   (s_delta_bound),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_unit       (m_is_unit),
        .m_delta         (m_delta),
        .m_unit_fraction (m_unit_fraction),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

### rtl/khbd_ctrl.sv
// Sequencer that steps the datapath through hashing, mixing, reduction and output.
module khbd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  khbd_pkg::dp_stat_t stat,
    output khbd_pkg::dp_cmd_t  cmd
);
    import khbd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_XS30 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_XS27 = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_XS31 = 4'd5;
    localparam logic [3:0] S_KEY  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg, state_next;
    mul_phase_t mphase_reg, mphase_next;
    logic       round_reg, round_next;
    logic [5:0] dcnt_reg, dcnt_next;

    assign s_ready = (state_reg == S_IDLE);

    // Decode state into the next step and datapath command
    always_comb begin
        state_next  = state_reg;
        mphase_next = mphase_reg;
        round_next  = round_reg;
        dcnt_next   = dcnt_reg;
        cmd.op        = DP_NOP;
        cmd.mul_sel   = 1'b0;
        cmd.mul_phase = mphase_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_BYTE) begin
                        cmd.op = DP_HASH;
                    end else if (s_op == OP_DELTA || s_op == OP_UNIT) begin
                        cmd.op     = DP_LOAD;
                        round_next = 1'b0;
                        state_next = S_XS30;
                    end
                end
            end
            S_XS30: begin
                cmd.op      = DP_XS30;
                mphase_next = MPH_LL;
                state_next  = S_MUL1;
            end
            S_MUL1: begin
                cmd.op = DP_MUL;
                if (mphase_reg == MPH_HL) begin
                    mphase_next = MPH_LL;
                    state_next  = S_XS27;
                end else begin
                    mphase_next = mphase_reg + 2'd1;
                end
            end
            S_XS27: begin
                cmd.op      = DP_XS27;
                mphase_next = MPH_LL;
                state_next  = S_MUL2;
            end
            S_MUL2: begin
                cmd.op      = DP_MUL;
                cmd.mul_sel = 1'b1;
                if (mphase_reg == MPH_HL) begin
                    mphase_next = MPH_LL;
                    state_next  = S_XS31;
                end else begin
                    mphase_next = mphase_reg + 2'd1;
                end
            end
            S_XS31: begin
                cmd.op = DP_XS31;
                if (!round_reg) begin
                    state_next = S_KEY;
                end else if (stat.is_unit || stat.bound_zero) begin
                    state_next = S_DONE;
                end else begin
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_KEY: begin
                cmd.op     = DP_KEY;
                round_next = 1'b1;
                state_next = S_XS30;
            end
            S_DIV: begin
                cmd.op    = DP_DIV;
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == '1) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output slot can take the beat
                if (!stat.out_busy) begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mphase_reg <= MPH_LL;
            round_reg  <= 1'b0;
            dcnt_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            mphase_reg <= mphase_next;
            round_reg  <= round_next;
            dcnt_reg   <= dcnt_next;
        end
    end

endmodule

### rtl/khbd_dp.sv
// Datapath: domain hash, mixer word with shared 32x32 multiplier, serial remainder, output register.
module khbd_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [63:0]        cfg_wr_data,
    input  logic [1:0]         s_op,
    input  logic [7:0]         s_domain_byte,
    input  logic               s_domain_first,
    input  logic [63:0]        s_draw_index,
    input  logic signed [31:0] s_delta_bound,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_unit,
    output logic signed [31:0] m_delta,
    output logic [52:0]        m_unit_fraction,
    input  khbd_pkg::dp_cmd_t  cmd,
    output khbd_pkg::dp_stat_t stat
);
    import khbd_pkg::*;

    logic [63:0] seed_reg;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] acc_reg, acc_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] mag_reg;
    logic        unit_reg;
    logic        bzero_reg;
    logic        out_valid_reg;
    logic        out_unit_reg;
    logic [31:0] out_delta_reg;
    logic [52:0] out_frac_reg;

    logic [63:0] hash_x;
    logic [31:0] in_mag;
    logic [63:0] mul_b;
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;
    logic [33:0] trial;
    logic [33:0] span;

    // Fold one byte: (h ^ byte) * (2^40 + 0x1B3)
    always_comb begin
        hash_x    = (s_domain_first ? FNV_BASIS : hash_reg) ^ {56'd0, s_domain_byte};
        hash_next = 64'(hash_x * {55'd0, FNV_PRIME_LO}) + (hash_x << FNV_PRIME_SH);
    end

    // Magnitude of the bound; the most negative value wraps to 2^31 as unsigned
    assign in_mag = s_delta_bound[31] ? 32'(-s_delta_bound) : s_delta_bound;

    // One 32x32 partial product per cycle
    always_comb begin
        mul_b = cmd.mul_sel ? MIX_MUL2 : MIX_MUL1;
        mul_x = (cmd.mul_phase == MPH_HL) ? v_reg[63:32] : v_reg[31:0];
        mul_y = (cmd.mul_phase == MPH_LH) ? mul_b[63:32] : mul_b[31:0];
        prod  = {32'd0, mul_x} * {32'd0, mul_y};
    end

    // Restoring remainder step against span = 2*mag + 1
    always_comb begin
        span  = {1'b0, mag_reg, 1'b1};
        trial = {rem_reg, v_reg[63]};
    end

    // Select next datapath values
    always_comb begin
        v_next   = v_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        case (cmd.op)
            DP_LOAD: begin
                v_next   = s_draw_index + MIX_GAMMA;
                rem_next = '0;
            end
            DP_XS30: v_next = v_reg ^ (v_reg >> 30);
            DP_XS27: v_next = v_reg ^ (v_reg >> 27);
            DP_XS31: v_next = v_reg ^ (v_reg >> 31);
            DP_KEY:  v_next = (v_reg ^ seed_reg ^ hash_reg) + MIX_GAMMA;
            DP_MUL: begin
                case (cmd.mul_phase)
                    MPH_LL:  acc_next = prod;
                    MPH_LH:  acc_next = acc_reg + {prod[31:0], 32'd0};
                    MPH_HL:  v_next   = acc_reg + {prod[31:0], 32'd0};
                    default: acc_next = acc_reg;
                endcase
            end
            DP_DIV: begin
                v_next   = v_reg << 1;
                rem_next = (trial >= span) ? 33'(trial - span) : trial[32:0];
            end
            default: v_next = v_reg;
        endcase
    end

    // Working registers
    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (cmd.op == DP_LOAD) begin
            mag_reg   <= in_mag;
            unit_reg  <= (s_op == OP_UNIT);
            bzero_reg <= (s_delta_bound == 32'sd0);
        end
    end

    // Seed and domain hash keep their reset values until written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            hash_reg <= FNV_BASIS;
        end else begin
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            if (cmd.op == DP_HASH) begin
                hash_reg <= hash_next;
            end
        end
    end

    // Output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == DP_OUT) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_OUT) begin
            out_unit_reg  <= unit_reg;
            out_delta_reg <= (unit_reg || bzero_reg) ? 32'd0 : (rem_reg[31:0] - mag_reg);
            out_frac_reg  <= unit_reg ? v_reg[63:11] : 53'd0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_is_unit       = out_unit_reg;
    assign m_delta         = out_delta_reg;
    assign m_unit_fraction = out_frac_reg;

    assign stat.is_unit    = unit_reg;
    assign stat.bound_zero = bzero_reg;
    assign stat.out_busy   = out_valid_reg & ~m_ready;

endmodule

### rtl/khbd_chk.sv
// Port-level checker for the keyed draw block and its bind to the top level.
module khbd_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_op,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_is_unit,
    input logic signed [31:0] m_delta,
    input logic [52:0]        m_unit_fraction
);
    import khbd_pkg::*;

    // Reset empties the output slot
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output beat valid after reset");

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // A draw beat occupies the block
    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_DELTA || s_op == OP_UNIT) |=> !s_ready)
        else $error("input taken while a draw is in progress");

    // A domain byte is folded in without stalling the input
    a_byte_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_BYTE |=> s_ready)
        else $error("domain byte stalled the input");

    // Only the field of the result kind may be nonzero
    a_field_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_unit ? (m_delta == 32'sd0) : (m_unit_fraction == 53'd0)))
        else $error("result carries a field of the other kind");

endmodule

bind keyed_hash_bounded_draw khbd_chk u_khbd_chk (.*);
